>>> sv/assert_macros.svh
// Assertion macros used by the padding address generator RTL.
// Each macro names its clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/pad2d_pkg.sv
// Types and constants for the 2-D padding address generator.
// No dependencies; every other file except assert_macros.svh imports this package.
`default_nettype none

package pad2d_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 10;
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 11;
    localparam int PAD_W    = 10;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SRC_W    = 46;
    localparam int DST_W    = 50;

    localparam int IDX_W    = SAMPLE_W + DIM_W;
    localparam int OHW_W    = 2 * COORD_W;
    localparam int HW_W     = 2 * DIM_W;
    localparam int DPROD_W  = IDX_W + OHW_W;
    localparam int SPROD_W  = IDX_W + HW_W;

    localparam logic [MODE_W-1:0] MODE_ZERO      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYMMETRIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REFLECT   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CFG = 2'd2;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAD_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAD_X     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS  = 3'd5;

    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_index;
        logic [CHAN_W-1:0]   channel_index;
        logic [COORD_W-1:0]  out_row;
        logic [COORD_W-1:0]  out_col;
    } pad2d_in_t;

    typedef struct packed {
        logic [SRC_W-1:0]    src_address;
        logic [DST_W-1:0]    dst_address;
        logic                is_padding;
        logic [STATUS_W-1:0] status;
    } pad2d_out_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  in_height;
        logic [DIM_W-1:0]  in_width;
        logic [PAD_W-1:0]  pad_y;
        logic [PAD_W-1:0]  pad_x;
        logic [DIM_W-1:0]  channels;
    } pad2d_cfg_t;

endpackage

`default_nettype wire

>>> sv/pad2d_apb_regs.sv
// APB register file for the padding configuration and its validity check.
// Depends on pad2d_pkg.
`default_nettype none

module pad2d_apb_regs import pad2d_pkg::*; #(
    parameter int unsigned MAX_DIM      = 1024,
    parameter int unsigned MAX_CHANNELS = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output pad2d_cfg_t                 cfg,
    output logic                       cfg_bad
);

    pad2d_cfg_t             cfg_reg;
    pad2d_cfg_t             cfg_next;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:      cfg_next.mode      = pwdata[MODE_W-1:0];
                REG_IN_HEIGHT: cfg_next.in_height = pwdata[DIM_W-1:0];
                REG_IN_WIDTH:  cfg_next.in_width  = pwdata[DIM_W-1:0];
                REG_PAD_Y:     cfg_next.pad_y     = pwdata[PAD_W-1:0];
                REG_PAD_X:     cfg_next.pad_x     = pwdata[PAD_W-1:0];
                REG_CHANNELS:  cfg_next.channels  = pwdata[DIM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_ZERO;
            cfg_reg.in_height <= DIM_W'(1);
            cfg_reg.in_width  <= DIM_W'(1);
            cfg_reg.pad_y     <= '0;
            cfg_reg.pad_x     <= '0;
            cfg_reg.channels  <= DIM_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:      prdata = APB_DATA_W'(cfg_reg.mode);
            REG_IN_HEIGHT: prdata = APB_DATA_W'(cfg_reg.in_height);
            REG_IN_WIDTH:  prdata = APB_DATA_W'(cfg_reg.in_width);
            REG_PAD_Y:     prdata = APB_DATA_W'(cfg_reg.pad_y);
            REG_PAD_X:     prdata = APB_DATA_W'(cfg_reg.pad_x);
            REG_CHANNELS:  prdata = APB_DATA_W'(cfg_reg.channels);
            default:       prdata = '0;
        endcase
    end

    // The padding on each side must be smaller than the image along that axis.
    assign cfg_bad = (cfg_reg.mode != MODE_ZERO && cfg_reg.mode != MODE_SYMMETRIC &&
                      cfg_reg.mode != MODE_REFLECT) ||
                     (cfg_reg.in_height == '0) || (32'(cfg_reg.in_height) > MAX_DIM) ||
                     (cfg_reg.in_width == '0)  || (32'(cfg_reg.in_width) > MAX_DIM) ||
                     (cfg_reg.channels == '0)  || (32'(cfg_reg.channels) > MAX_CHANNELS) ||
                     ({1'b0, cfg_reg.pad_y} >= cfg_reg.in_height) ||
                     ({1'b0, cfg_reg.pad_x} >= cfg_reg.in_width);

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/pad2d_fold.sv
// Maps one padded coordinate onto the unpadded axis for all three border modes.
// Depends on pad2d_pkg.
`default_nettype none

module pad2d_fold import pad2d_pkg::*; (
    input  wire logic [COORD_W-1:0] pos,
    input  wire logic [DIM_W-1:0]   size,
    input  wire logic [PAD_W-1:0]   pad,
    input  wire logic [MODE_W-1:0]  mode,
    output logic      [DIM_W-1:0]   src_pos,
    output logic                    border
);

    localparam int EXT_W = COORD_W + 1;

    logic [EXT_W-1:0] lead_dist;
    logic [EXT_W-1:0] pos_off;
    logic [EXT_W-1:0] trail_dist;
    logic             in_lead;
    logic             in_trail;

    always_comb begin
        lead_dist  = EXT_W'(pad) - EXT_W'(pos);
        pos_off    = EXT_W'(pos) - EXT_W'(pad);
        trail_dist = pos_off - EXT_W'(size);
        in_lead    = pos < COORD_W'(pad);
        in_trail   = !in_lead && (pos_off >= EXT_W'(size));
        border     = in_lead || in_trail;
        src_pos    = DIM_W'(pos_off);
        if (in_lead) begin
            case (mode)
                MODE_SYMMETRIC: src_pos = DIM_W'(lead_dist - EXT_W'(1));
                MODE_REFLECT:   src_pos = DIM_W'(lead_dist);
                default:        src_pos = '0;
            endcase
        end else if (in_trail) begin
            case (mode)
                MODE_SYMMETRIC: src_pos = DIM_W'(EXT_W'(size) - EXT_W'(1) - trail_dist);
                MODE_REFLECT:   src_pos = DIM_W'(EXT_W'(size) - EXT_W'(2) - trail_dist);
                default:        src_pos = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/pad2d_pipe.sv
// Four-stage address pipeline: range check and fold, small products,
// wide products, final sums into the output register. Depends on pad2d_pkg,
// pad2d_fold and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pad2d_pipe import pad2d_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 65536
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pad2d_cfg_t cfg,
    input  wire logic       cfg_bad,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire pad2d_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output pad2d_out_t      m_data
);

    // Stage 1 combinational terms.
    logic [DIM_W-1:0]    src_row;
    logic [DIM_W-1:0]    src_col;
    logic                row_border;
    logic                col_border;
    logic [COORD_W-1:0]  out_h;
    logic [COORD_W-1:0]  out_w;
    logic                out_of_range;
    logic [STATUS_W-1:0] status_c;

    // Stage 1 registers.
    logic                s1_valid_reg;
    logic [STATUS_W-1:0] s1_status_reg;
    logic                s1_pad_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [COORD_W-1:0]  s1_row_reg;
    logic [COORD_W-1:0]  s1_col_reg;
    logic [DIM_W-1:0]    s1_src_row_reg;
    logic [DIM_W-1:0]    s1_src_col_reg;
    logic [COORD_W-1:0]  s1_out_h_reg;
    logic [COORD_W-1:0]  s1_out_w_reg;

    // Stage 2 registers.
    logic                s2_valid_reg;
    logic [STATUS_W-1:0] s2_status_reg;
    logic                s2_pad_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    logic [OHW_W-1:0]    s2_ohw_reg;
    logic [HW_W-1:0]     s2_hw_reg;
    logic [OHW_W-1:0]    s2_dpos_reg;
    logic [HW_W-1:0]     s2_spos_reg;

    // Stage 3 registers.
    logic                s3_valid_reg;
    logic [STATUS_W-1:0] s3_status_reg;
    logic                s3_pad_reg;
    logic [DPROD_W-1:0]  s3_dprod_reg;
    logic [SPROD_W-1:0]  s3_sprod_reg;
    logic [OHW_W-1:0]    s3_dpos_reg;
    logic [HW_W-1:0]     s3_spos_reg;

    // Output register.
    logic                out_valid_reg;
    pad2d_out_t          out_data_reg;
    pad2d_out_t          out_data_next;
    logic [DPROD_W-1:0]  dst_sum;
    logic [SPROD_W-1:0]  src_sum;

    logic                s1_ready;
    logic                s2_ready;
    logic                s3_ready;
    logic                out_ready;

    logic                out_err;
    logic                out_clear;
    logic                out_pad;
    logic                out_pad_ok;

    assign out_ready = !out_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;

    pad2d_fold u_fold_row (
        .pos     (s_data.out_row),
        .size    (cfg.in_height),
        .pad     (cfg.pad_y),
        .mode    (cfg.mode),
        .src_pos (src_row),
        .border  (row_border)
    );

    pad2d_fold u_fold_col (
        .pos     (s_data.out_col),
        .size    (cfg.in_width),
        .pad     (cfg.pad_x),
        .mode    (cfg.mode),
        .src_pos (src_col),
        .border  (col_border)
    );

    always_comb begin
        out_h = COORD_W'(cfg.in_height) + {1'b0, cfg.pad_y, 1'b0};
        out_w = COORD_W'(cfg.in_width) + {1'b0, cfg.pad_x, 1'b0};
        out_of_range = (32'(s_data.sample_index) >= MAX_SAMPLES) ||
                       ({1'b0, s_data.channel_index} >= cfg.channels) ||
                       (s_data.out_row >= out_h) || (s_data.out_col >= out_w);
        if (cfg_bad) begin
            status_c = STATUS_BAD_CFG;
        end else if (out_of_range) begin
            status_c = STATUS_RANGE;
        end else begin
            status_c = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_status_reg  <= status_c;
            s1_pad_reg     <= (cfg.mode == MODE_ZERO) && (row_border || col_border);
            s1_idx_reg     <= IDX_W'(s_data.sample_index) * IDX_W'(cfg.channels) +
                              IDX_W'(s_data.channel_index);
            s1_row_reg     <= s_data.out_row;
            s1_col_reg     <= s_data.out_col;
            s1_src_row_reg <= src_row;
            s1_src_col_reg <= src_col;
            s1_out_h_reg   <= out_h;
            s1_out_w_reg   <= out_w;
        end
        if (s2_ready) begin
            s2_status_reg <= s1_status_reg;
            s2_pad_reg    <= s1_pad_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_ohw_reg    <= OHW_W'(s1_out_h_reg) * OHW_W'(s1_out_w_reg);
            s2_hw_reg     <= HW_W'(cfg.in_height) * HW_W'(cfg.in_width);
            s2_dpos_reg   <= OHW_W'(s1_row_reg) * OHW_W'(s1_out_w_reg) + OHW_W'(s1_col_reg);
            s2_spos_reg   <= HW_W'(s1_src_row_reg) * HW_W'(cfg.in_width) +
                             HW_W'(s1_src_col_reg);
        end
        if (s3_ready) begin
            s3_status_reg <= s2_status_reg;
            s3_pad_reg    <= s2_pad_reg;
            s3_dprod_reg  <= DPROD_W'(s2_idx_reg) * DPROD_W'(s2_ohw_reg);
            s3_sprod_reg  <= SPROD_W'(s2_idx_reg) * SPROD_W'(s2_hw_reg);
            s3_dpos_reg   <= s2_dpos_reg;
            s3_spos_reg   <= s2_spos_reg;
        end
        if (out_ready) begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb begin
        dst_sum = s3_dprod_reg + DPROD_W'(s3_dpos_reg);
        src_sum = s3_sprod_reg + SPROD_W'(s3_spos_reg);
        out_data_next.status      = s3_status_reg;
        out_data_next.is_padding  = 1'b0;
        out_data_next.dst_address = '0;
        out_data_next.src_address = '0;
        if (s3_status_reg == STATUS_OK) begin
            out_data_next.dst_address = DST_W'(dst_sum);
            out_data_next.is_padding  = s3_pad_reg;
            if (!s3_pad_reg) begin
                out_data_next.src_address = SRC_W'(src_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign out_err    = out_valid_reg && out_data_reg.status != STATUS_OK;
    assign out_clear  = out_data_reg.src_address == '0 && out_data_reg.dst_address == '0 &&
                        !out_data_reg.is_padding;
    assign out_pad    = out_valid_reg && out_data_reg.is_padding;
    assign out_pad_ok = out_data_reg.src_address == '0 && out_data_reg.status == STATUS_OK;

    `ASSERT_IMPL(a_err_zeroes, aclk, aresetn, out_err, out_clear)
    `ASSERT_IMPL(a_pad_no_src, aclk, aresetn, out_pad, out_pad_ok)
    `ASSERT_NEXT(a_s3_hold, aclk, aresetn, !s3_ready, s3_valid_reg && $stable(s3_dprod_reg))
    `ASSERT_NEXT(a_s3_hold_src, aclk, aresetn, !s3_ready, $stable(s3_sprod_reg))
    `ASSERT_NEXT(a_s1_hold, aclk, aresetn, !s1_ready, s1_valid_reg && $stable(s1_idx_reg))
    `ASSERT_NEXT(a_s1_hold_status, aclk, aresetn, !s1_ready, $stable(s1_status_reg))

endmodule

`default_nettype wire

>>> sv/pad2d_source_address.sv
// Padding address generator top level: APB configuration and address pipeline.
// Four register stages (stage 1, 2, 3 and output) each stall only when full; an accepted
// beat passes them in order. Throughput: one beat per cycle while m_ready is high.
// Reset (aresetn, synchronous, active low) empties the pipeline and restores the
// configuration to mode 0, 1x1 image, no padding, one channel. Depends on pad2d_pkg.
`default_nettype none

module pad2d_source_address import pad2d_pkg::*; #(
    parameter int unsigned MAX_DIM      = 1024,
    parameter int unsigned MAX_CHANNELS = 1024,
    parameter int unsigned MAX_SAMPLES  = 65536
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pad2d_in_t             s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pad2d_out_t                 m_data
);

    pad2d_cfg_t cfg;
    logic       cfg_bad;

    pad2d_apb_regs #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_bad (cfg_bad)
    );

    pad2d_pipe #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cfg_bad (cfg_bad),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> dv/pad2d_tb_pkg.sv
// Scoreboard for the 2-D padding address generator testbench.
// Predicts source and destination addresses from a shadow copy of the registers.
// Depends on pad2d_pkg.
`timescale 1ns / 1ps

package pad2d_tb_pkg;
    import pad2d_pkg::*;

    localparam longint unsigned DIM_LIMIT     = 1024;
    localparam longint unsigned CHANNEL_LIMIT = 1024;
    localparam longint unsigned SAMPLE_LIMIT  = 65536;
    localparam int              PRINT_LIMIT   = 100;

    class pad2d_addr_scoreboard;
        pad2d_cfg_t cfg;
        pad2d_out_t expected_addrs[$];
        int errors;
        int n_checked;
        int n_addressed;
        int n_border;
        int n_range;
        int n_bad_cfg;

        function new();
            cfg = '{mode: MODE_ZERO, in_height: 11'd1, in_width: 11'd1,
                    pad_y: '0, pad_x: '0, channels: 11'd1};
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
            case (idx)
                REG_MODE:      cfg.mode      = val[MODE_W-1:0];
                REG_IN_HEIGHT: cfg.in_height = val[DIM_W-1:0];
                REG_IN_WIDTH:  cfg.in_width  = val[DIM_W-1:0];
                REG_PAD_Y:     cfg.pad_y     = val[PAD_W-1:0];
                REG_PAD_X:     cfg.pad_x     = val[PAD_W-1:0];
                REG_CHANNELS:  cfg.channels  = val[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned fold_coord(longint unsigned p, longint unsigned n,
                                             longint unsigned pad, logic [MODE_W-1:0] m,
                                             inout bit border);
            if (p < pad) begin
                border = 1'b1;
                if (m == MODE_SYMMETRIC) return pad - p - 1;
                if (m == MODE_REFLECT) return pad - p;
                return 0;
            end
            if (p >= pad + n) begin
                border = 1'b1;
                if (m == MODE_SYMMETRIC) return n - 1 - (p - pad - n);
                if (m == MODE_REFLECT) return n - 2 - (p - pad - n);
                return 0;
            end
            return p - pad;
        endfunction

        function pad2d_out_t predict_addresses(pad2d_in_t beat);
            pad2d_out_t      r;
            longint unsigned h, w, py, px, nc, oh, ow;
            longint unsigned s, ch, row, col, sr, sc, base;
            bit              border;
            r   = '0;
            h   = cfg.in_height;
            w   = cfg.in_width;
            py  = cfg.pad_y;
            px  = cfg.pad_x;
            nc  = cfg.channels;
            s   = beat.sample_index;
            ch  = beat.channel_index;
            row = beat.out_row;
            col = beat.out_col;
            if (cfg.mode > MODE_REFLECT || h == 0 || h > DIM_LIMIT || w == 0 ||
                w > DIM_LIMIT || nc == 0 || nc > CHANNEL_LIMIT ||
                py > h - 1 || px > w - 1) begin
                r.status = STATUS_BAD_CFG;
                return r;
            end
            oh = h + 2 * py;
            ow = w + 2 * px;
            if (s >= SAMPLE_LIMIT || ch >= nc || row >= oh || col >= ow) begin
                r.status = STATUS_RANGE;
                return r;
            end
            base = s * nc + ch;
            r.dst_address = DST_W'(base * oh * ow + row * ow + col);
            r.status = STATUS_OK;
            border = 1'b0;
            sr = fold_coord(row, h, py, cfg.mode, border);
            sc = fold_coord(col, w, px, cfg.mode, border);
            if (cfg.mode == MODE_ZERO && border) begin
                r.is_padding = 1'b1;
                return r;
            end
            r.src_address = SRC_W'(base * h * w + sr * w + sc);
            return r;
        endfunction

        function void note_beat(pad2d_in_t beat);
            expected_addrs.push_back(predict_addresses(beat));
        endfunction

        function int pending();
            return expected_addrs.size();
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            if (errors < PRINT_LIMIT)
                $display("mismatch at %0t: %s got 0x%0h expected 0x%0h",
                         $realtime, what, got, want);
            errors++;
        endtask

        task check_beat(pad2d_out_t got);
            pad2d_out_t want;
            if (expected_addrs.size() == 0) begin
                report_mismatch("result beat with nothing pending, status", got.status, 0);
                return;
            end
            want = expected_addrs.pop_front();
            n_checked++;
            case (want.status)
                STATUS_OK:    if (want.is_padding) n_border++; else n_addressed++;
                STATUS_RANGE: n_range++;
                default:      n_bad_cfg++;
            endcase
            if (got.src_address !== want.src_address)
                report_mismatch("src_address", got.src_address, want.src_address);
            if (got.dst_address !== want.dst_address)
                report_mismatch("dst_address", got.dst_address, want.dst_address);
            if (got.is_padding !== want.is_padding)
                report_mismatch("is_padding", got.is_padding, want.is_padding);
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
        endtask
    endclass

endpackage

>>> dv/tb_top.sv
// Top-level testbench for pad2d_source_address: APB register setup, stream stimulus
// with random idling on both sides, and result checking. Depends on pad2d_pkg and
// pad2d_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
    import pad2d_pkg::*;
    import pad2d_tb_pkg::*;

    localparam int CYCLE_LIMIT           = 400000;
    localparam int RANDOM_SETTINGS       = 27;
    localparam int BEATS_PER_SETTING     = 90;
    localparam int BEATS_PER_BAD_SETTING = 20;
    localparam int DRAIN_CYCLES          = 8;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    typedef enum int {
        BAD_MODE, BAD_H_ZERO, BAD_H_BIG, BAD_W_ZERO, BAD_W_BIG,
        BAD_C_ZERO, BAD_C_BIG, BAD_PAD_Y, BAD_PAD_X
    } bad_cfg_e;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    pad2d_in_t             s_data   = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    pad2d_out_t            m_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int settings_used = 0;

    pad2d_addr_scoreboard sb;

    pad2d_source_address u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_data);
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(input pad2d_cfg_t c);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_MODE,      APB_DATA_W'(c.mode));
        write_reg(REG_IN_HEIGHT, APB_DATA_W'(c.in_height));
        write_reg(REG_IN_WIDTH,  APB_DATA_W'(c.in_width));
        write_reg(REG_PAD_Y,     APB_DATA_W'(c.pad_y));
        write_reg(REG_PAD_X,     APB_DATA_W'(c.pad_x));
        write_reg(REG_CHANNELS,  APB_DATA_W'(c.channels));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic drive_beat(input pad2d_in_t beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(beat);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int n, int pad);
        int total;
        int v;
        total = n + 2 * pad;
        if (total < 1) total = 1;
        if (total > 4096) total = 4096;
        case ($urandom_range(0, 7))
            0: v = pad - 1;
            1: v = pad;
            2: v = pad + n - 1;
            3: v = pad + n;
            4: v = 0;
            5: v = total - 1;
            default: v = $urandom_range(0, total - 1);
        endcase
        if (v < 0) v = 0;
        if (v >= total) v = total - 1;
        return COORD_W'(v);
    endfunction

    function automatic pad2d_in_t random_beat(pad2d_cfg_t c);
        pad2d_in_t b;
        int        nc;
        b.sample_index = SAMPLE_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            b.channel_index = CHAN_W'($urandom);
            b.out_row       = COORD_W'($urandom);
            b.out_col       = COORD_W'($urandom);
        end else begin
            nc = (c.channels == 0) ? 1 : ((c.channels > 1024) ? 1024 : int'(c.channels));
            b.channel_index = CHAN_W'($urandom_range(0, nc - 1));
            b.out_row       = pick_coord(int'(c.in_height), int'(c.pad_y));
            b.out_col       = pick_coord(int'(c.in_width), int'(c.pad_x));
        end
        return b;
    endfunction

    function automatic pad2d_cfg_t make_config(int p);
        pad2d_cfg_t c;
        int         k;
        int         sel;
        int         h;
        int         w;
        k   = p / 3;
        sel = (p % 3 == 1) ? (k + 1) % 3 : k % 3;
        case (sel)
            0:       c.mode = MODE_ZERO;
            1:       c.mode = MODE_SYMMETRIC;
            default: c.mode = MODE_REFLECT;
        endcase
        h = $urandom_range(1, 8);
        w = $urandom_range(1, 8);
        c.in_height = DIM_W'(h);
        c.in_width  = DIM_W'(w);
        c.pad_y     = PAD_W'($urandom_range(0, h - 1));
        c.pad_x     = PAD_W'($urandom_range(0, w - 1));
        c.channels  = DIM_W'($urandom_range(1, 4));
        if (p % 3 == 1) begin
            if (k % 4 == 0) begin
                c.in_height = DIM_W'(1024);
                c.in_width  = DIM_W'(1024);
                c.pad_y     = PAD_W'(1023);
                c.pad_x     = PAD_W'(1023);
                c.channels  = DIM_W'(1024);
            end else begin
                h = $urandom_range(1, 1024);
                w = $urandom_range(1, 1024);
                c.in_height = DIM_W'(h);
                c.in_width  = DIM_W'(w);
                c.pad_y     = PAD_W'($urandom_range(0, h - 1));
                c.pad_x     = PAD_W'($urandom_range(0, w - 1));
                c.channels  = DIM_W'($urandom_range(1, 1024));
            end
        end else if (p % 3 == 2) begin
            case (bad_cfg_e'(k))
                BAD_MODE:   c.mode      = MODE_INVALID;
                BAD_H_ZERO: c.in_height = '0;
                BAD_H_BIG:  c.in_height = DIM_W'($urandom_range(1025, 2047));
                BAD_W_ZERO: c.in_width  = '0;
                BAD_W_BIG:  c.in_width  = DIM_W'($urandom_range(1025, 2047));
                BAD_C_ZERO: c.channels  = '0;
                BAD_C_BIG:  c.channels  = DIM_W'($urandom_range(1025, 2047));
                BAD_PAD_Y:  c.pad_y     = PAD_W'($urandom_range(h, 1023));
                BAD_PAD_X:  c.pad_x     = PAD_W'($urandom_range(w, 1023));
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic run_directed();
        pad2d_cfg_t c;
        int         oh;
        int         ow;
        for (int i = 0; i < 5; i++) begin
            c = '{mode: MODE_ZERO, in_height: 11'd3, in_width: 11'd4,
                  pad_y: 10'd2, pad_x: 10'd3, channels: 11'd2};
            case (i)
                0: c = sb.cfg;
                2: c.mode = MODE_SYMMETRIC;
                3: c.mode = MODE_REFLECT;
                4: c.mode = MODE_INVALID;
                default: ;
            endcase
            if (i != 0) apply_config(c);
            oh = int'(c.in_height) + 2 * int'(c.pad_y);
            ow = int'(c.in_width) + 2 * int'(c.pad_x);
            drive_beat('0);
            drive_beat('{sample_index: '1, channel_index: CHAN_W'(c.channels - 1),
                         out_row: COORD_W'(oh - 1), out_col: COORD_W'(ow - 1)});
            drive_beat('{sample_index: SAMPLE_W'(1), channel_index: '0,
                         out_row: COORD_W'(c.pad_y), out_col: COORD_W'(c.pad_x)});
            drive_beat('{sample_index: '0, channel_index: '1, out_row: '0, out_col: '0});
            drive_beat('{sample_index: '0, channel_index: '0, out_row: '1,
                         out_col: COORD_W'(ow)});
        end
    endtask

    initial begin
        pad2d_cfg_t phase_cfg;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int p = 0; p < RANDOM_SETTINGS; p++) begin
            phase_cfg = make_config(p);
            apply_config(phase_cfg);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            repeat ((p % 3 == 2) ? BEATS_PER_BAD_SETTING : BEATS_PER_SETTING)
                drive_beat(random_beat(phase_cfg));
        end
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("checked %0d result beats across %0d register settings in %0d cycles",
                 sb.n_checked, settings_used, cycle_count);
        $display("addressed %0d, zero border %0d, out of range %0d, bad setup %0d, errors %0d",
                 sb.n_addressed, sb.n_border, sb.n_range, sb.n_bad_cfg, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
